// ===== hdl/mlp2c_pkg.sv =====
package mlp2c_pkg;

   // Operation codes carried in the operation field of a request beat.
   typedef enum logic [2:0] {
      OP_HIDDEN_WEIGHT = 3'd0,
      OP_HIDDEN_BIAS   = 3'd1,
      OP_OUTPUT_WEIGHT = 3'd2,
      OP_OUTPUT_BIAS   = 3'd3,
      OP_FEATURE       = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Regions of the weight memory (top address bit).
   localparam logic WREG_HIDDEN = 1'b0;
   localparam logic WREG_OUTPUT = 1'b1;

   // Regions of the vector memory (top two address bits).
   localparam logic [1:0] VREG_HBIAS = 2'd0;
   localparam logic [1:0] VREG_OBIAS = 2'd1;
   localparam logic [1:0] VREG_FEAT  = 2'd2;
   localparam logic [1:0] VREG_ACT   = 2'd3;

   typedef struct packed {
      logic [2:0]         operation;
      logic [5:0]         row_index;
      logic [5:0]         column_index;
      logic signed [31:0] value;
      logic               last_feature;
   } req_type;

   typedef struct packed {
      logic [6:0]         predicted_class;
      logic signed [31:0] top_logit;
   } rsp_type;

   // Sequencer to datapath controls.
   typedef struct packed {
      logic issue;
      logic bias;
      logic finish;
      logic out_layer;
      logic first_row;
      logic last_row;
   } ctl_type;

endpackage

// ===== hdl/mlp2c_ram.sv =====
module mlp2c_ram #(
   parameter int ADDR_WIDTH = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [2**ADDR_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/mlp2c_ctrl.sv =====
module mlp2c_ctrl
   import mlp2c_pkg::*;
#(
   parameter int INPUT_COUNT  = 16,
   parameter int HIDDEN_COUNT = 16,
   parameter int CLASS_COUNT  = 4,
   parameter int IW = 4,
   parameter int HW = 4,
   parameter int CW = 2,
   parameter int RW = 4,
   parameter int KW = 4,
   parameter int WW = 8,
   parameter int VW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic          pipe_busy,
   output logic          busy,
   output ctl_type       ctl,
   output logic [RW-1:0] row,
   output logic [WW:0]   w_rd_addr,
   output logic [VW+1:0] v_rd_addr
);

   state_type     state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [KW-1:0] k_ff, k_in;
   logic          layer_ff, layer_in;
   logic          last_k;
   logic          last_row;

   assign last_k   = layer_ff ? (k_ff == KW'(HIDDEN_COUNT - 1))
                              : (k_ff == KW'(INPUT_COUNT - 1));
   assign last_row = layer_ff ? (row_ff == RW'(CLASS_COUNT - 1))
                              : (row_ff == RW'(HIDDEN_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = (last_row && layer_ff) ? ST_IDLE : ST_BIAS;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Row, column and layer counters.
   always_comb begin
      row_in   = row_ff;
      k_in     = k_ff;
      layer_in = layer_ff;
      case (state_ff)
         ST_IDLE: begin
            row_in   = '0;
            layer_in = 1'b0;
         end
         ST_BIAS: begin
            k_in = '0;
         end
         ST_MAC: begin
            k_in = k_ff + KW'(1);
         end
         ST_FINISH: begin
            if (last_row) begin
               row_in   = '0;
               layer_in = 1'b1;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ctl.issue     = (state_ff == ST_BIAS) || (state_ff == ST_MAC);
      ctl.bias      = (state_ff == ST_BIAS);
      ctl.finish    = (state_ff == ST_FINISH);
      ctl.out_layer = layer_ff;
      ctl.first_row = (row_ff == '0);
      ctl.last_row  = last_row;
      busy          = (state_ff != ST_IDLE);
      if (layer_ff) begin
         w_rd_addr = {WREG_OUTPUT, WW'({row_ff[CW-1:0], k_ff[HW-1:0]})};
      end else begin
         w_rd_addr = {WREG_HIDDEN, WW'({row_ff[HW-1:0], k_ff[IW-1:0]})};
      end
      if (state_ff == ST_BIAS) begin
         v_rd_addr = layer_ff ? {VREG_OBIAS, VW'(row_ff[CW-1:0])}
                              : {VREG_HBIAS, VW'(row_ff[HW-1:0])};
      end else begin
         v_rd_addr = layer_ff ? {VREG_ACT, VW'(k_ff[HW-1:0])}
                              : {VREG_FEAT, VW'(k_ff[IW-1:0])};
      end
   end

   assign row = row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         k_ff     <= '0;
         layer_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         k_ff     <= k_in;
         layer_ff <= layer_in;
      end
   end

endmodule

// ===== hdl/mlp2c_datapath.sv =====
module mlp2c_datapath
   import mlp2c_pkg::*;
#(
   parameter int RW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       ctl,
   input  logic [RW-1:0] row,
   input  logic [31:0]   w_rd_data,
   input  logic [31:0]   v_rd_data,
   output logic          pipe_busy,
   output logic [31:0]   act_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   logic        vld1_ff, bias1_ff;
   logic        vld2_ff, first2_ff;
   logic [31:0] term_ff, term_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] prod_lo;
   logic [31:0] best_ff;
   logic [6:0]  best_cls_ff;
   logic        take;
   logic [31:0] win_logit;
   logic [6:0]  win_cls;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   // Low word of the product equals the wrapped two's complement product.
   assign prod_lo = 32'(w_rd_data * v_rd_data);
   assign term_in = bias1_ff ? v_rd_data : prod_lo;
   assign acc_in  = first2_ff ? term_ff : acc_ff + term_ff;

   assign pipe_busy = vld1_ff || vld2_ff;
   assign act_data  = acc_ff[31] ? 32'd0 : acc_ff;

   assign take      = ctl.first_row || ($signed(acc_ff) > $signed(best_ff));
   assign win_logit = take ? acc_ff : best_ff;
   assign win_cls   = take ? (7'(row) + 7'd1) : best_cls_ff;

   assign rsp_valid_in = ctl.finish && ctl.out_layer && ctl.last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld1_ff      <= ctl.issue;
         vld2_ff      <= vld1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bias1_ff  <= ctl.bias;
      first2_ff <= bias1_ff;
      term_ff   <= term_in;
      if (vld2_ff) begin
         acc_ff <= acc_in;
      end
      if (ctl.finish && ctl.out_layer) begin
         best_ff     <= win_logit;
         best_cls_ff <= win_cls;
      end
      if (rsp_valid_in) begin
         rsp_ff.predicted_class <= win_cls;
         rsp_ff.top_logit       <= win_logit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/mlp_two_layer_classifier.sv =====
// Two-layer integer perceptron classifier. A request beat is taken on any
// clock edge where start is high and busy is low. Weight, bias and feature
// beats give no result. A feature beat with last_feature set starts
// inference, which holds busy high while a single multiply-accumulate unit,
// fed one weight and one operand per cycle from two single-port-read
// memories, works through every neuron with a bias read, a pipeline drain
// and a finishing step. The result beat follows on rsp_valid for exactly
// one cycle, at the same edge that busy falls; the receiver cannot stall
// it, so it must be captured then. Tables and buffers are not cleared by
// reset: every entry must be written before an inference reads it.
module mlp_two_layer_classifier
   import mlp2c_pkg::*;
#(
   parameter int INPUT_COUNT  = 16,
   parameter int HIDDEN_COUNT = 16,
   parameter int CLASS_COUNT  = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Index widths for each dimension, at least one bit each.
   localparam int IW = (INPUT_COUNT  > 1) ? $clog2(INPUT_COUNT)  : 1;
   localparam int HW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
   localparam int CW = (CLASS_COUNT  > 1) ? $clog2(CLASS_COUNT)  : 1;
   localparam int RW = (HW > CW) ? HW : CW;
   localparam int KW = (IW > HW) ? IW : HW;
   localparam int WW = ((HW + IW) > (CW + HW)) ? (HW + IW) : (CW + HW);
   localparam int VW = (KW > CW) ? KW : CW;

   logic          accept;
   logic          go;
   logic          pipe_busy;
   ctl_type       ctl;
   logic [RW-1:0] row;

   logic          w_wr_en;
   logic [WW:0]   w_wr_addr;
   logic [WW:0]   w_rd_addr;
   logic [31:0]   w_rd_data;

   logic          v_wr_en;
   logic [VW+1:0] v_wr_addr;
   logic [31:0]   v_wr_data;
   logic [VW+1:0] v_rd_addr;
   logic [31:0]   v_rd_data;
   logic [31:0]   act_data;

   logic          row_in_hidden;
   logic          row_in_class;
   logic          col_in_input;
   logic          col_in_hidden;

   assign accept = start && !busy;

   assign row_in_hidden = ({1'b0, req_data.row_index} < 7'(HIDDEN_COUNT));
   assign row_in_class  = ({1'b0, req_data.row_index} < 7'(CLASS_COUNT));
   assign col_in_input  = ({1'b0, req_data.column_index} < 7'(INPUT_COUNT));
   assign col_in_hidden = ({1'b0, req_data.column_index} < 7'(HIDDEN_COUNT));

   // Load decode. Loads only arrive while the sequencer is idle, and
   // activation write-back only happens while it is busy, so the vector
   // memory write port never sees both at once.
   always_comb begin
      w_wr_en   = 1'b0;
      w_wr_addr = {WREG_HIDDEN,
                   WW'({req_data.row_index[HW-1:0], req_data.column_index[IW-1:0]})};
      v_wr_en   = 1'b0;
      v_wr_addr = {VREG_FEAT, VW'(req_data.column_index[IW-1:0])};
      v_wr_data = req_data.value;
      go        = 1'b0;
      if (ctl.finish && !ctl.out_layer) begin
         v_wr_en   = 1'b1;
         v_wr_addr = {VREG_ACT, VW'(row[HW-1:0])};
         v_wr_data = act_data;
      end else if (accept) begin
         case (req_data.operation)
            OP_HIDDEN_WEIGHT: begin
               w_wr_en = row_in_hidden && col_in_input;
            end
            OP_HIDDEN_BIAS: begin
               v_wr_en   = row_in_hidden;
               v_wr_addr = {VREG_HBIAS, VW'(req_data.row_index[HW-1:0])};
            end
            OP_OUTPUT_WEIGHT: begin
               w_wr_en   = row_in_class && col_in_hidden;
               w_wr_addr = {WREG_OUTPUT,
                  WW'({req_data.row_index[CW-1:0], req_data.column_index[HW-1:0]})};
            end
            OP_OUTPUT_BIAS: begin
               v_wr_en   = row_in_class;
               v_wr_addr = {VREG_OBIAS, VW'(req_data.row_index[CW-1:0])};
            end
            OP_FEATURE: begin
               // A feature beyond the buffer is dropped, but its last flag
               // still starts inference.
               v_wr_en = col_in_input;
               go      = req_data.last_feature;
            end
            default: begin
            end
         endcase
      end
   end

   // Hidden and output weights share one memory, split by the top bit.
   mlp2c_ram #(
      .ADDR_WIDTH (WW + 1),
      .DATA_WIDTH (32)
   ) u_wmem (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (req_data.value),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   // Biases, features and hidden activations share the vector memory.
   mlp2c_ram #(
      .ADDR_WIDTH (VW + 2),
      .DATA_WIDTH (32)
   ) u_vmem (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   mlp2c_ctrl #(
      .INPUT_COUNT  (INPUT_COUNT),
      .HIDDEN_COUNT (HIDDEN_COUNT),
      .CLASS_COUNT  (CLASS_COUNT),
      .IW (IW),
      .HW (HW),
      .CW (CW),
      .RW (RW),
      .KW (KW),
      .WW (WW),
      .VW (VW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .pipe_busy (pipe_busy),
      .busy      (busy),
      .ctl       (ctl),
      .row       (row),
      .w_rd_addr (w_rd_addr),
      .v_rd_addr (v_rd_addr)
   );

   mlp2c_datapath #(
      .RW (RW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .row       (row),
      .w_rd_data (w_rd_data),
      .v_rd_data (v_rd_data),
      .pipe_busy (pipe_busy),
      .act_data  (act_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/testbench.sv =====
module testbench
   import mlp2c_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Sizes handed to the block; the predictor below works at the same sizes.
   localparam int N_IN  = 16;
   localparam int N_HID = 16;
   localparam int N_CLS = 4;

   // Operation codes that the block does not define and must ignore.
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // Useful beats wanted from the random part of the run.
   localparam int RANDOM_BEATS = 1350;
   // After the last result we allow longer than one inference keeps busy
   // high, for a stray beat to show itself.
   localparam int SETTLE_CYCLES = 500;
   // Cycles with neither a beat taken nor a result seen before giving up.
   // The slowest honest stretch is one inference plus a long sender gap.
   localparam int STALL_LIMIT = 5000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   mlp_two_layer_classifier #(
      .INPUT_COUNT  (N_IN),
      .HIDDEN_COUNT (N_HID),
      .CLASS_COUNT  (N_CLS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor: the network's tables as the block should hold them.
   // Everything is kept as raw 32-bit words so that products and sums
   // wrap exactly as two's complement hardware does.
   // ------------------------------------------------------------------
   bit [31:0] hid_w [N_HID][N_IN];
   bit [31:0] hid_b [N_HID];
   bit [31:0] out_w [N_CLS][N_HID];
   bit [31:0] out_b [N_CLS];
   bit [31:0] feat  [N_IN];
   bit [31:0] act   [N_HID];

   // Classifications still owed by the block, oldest first.
   rsp_type expected_verdicts [$];

   int mismatches       = 0;
   int verdicts_checked = 0;
   int beats_taken      = 0;
   int ignored_beats    = 0;
   int stall_cycles     = 0;
   bit steady           = 1'b0;  // set while the sender must not leave gaps

   // Runs the whole network on the current feature buffer. The hidden layer
   // goes through ReLU, then the first logit that is strictly greater than
   // all earlier ones wins, so ties go to the lowest class.
   function automatic rsp_type classify_sample();
      rsp_type   verdict;
      bit [31:0] acc;
      bit [31:0] best;
      int        best_idx;
      best     = '0;
      best_idx = 0;
      for (int h = 0; h < N_HID; h++) begin
         acc = hid_b[h];
         for (int i = 0; i < N_IN; i++) acc = acc + hid_w[h][i] * feat[i];
         act[h] = acc[31] ? 32'd0 : acc;
      end
      for (int c = 0; c < N_CLS; c++) begin
         acc = out_b[c];
         for (int h = 0; h < N_HID; h++) acc = acc + out_w[c][h] * act[h];
         if (c == 0 || $signed(acc) > $signed(best)) begin
            best     = acc;
            best_idx = c;
         end
      end
      verdict.predicted_class = 7'(best_idx + 1);
      verdict.top_logit       = best;
      return verdict;
   endfunction

   // Applies one accepted beat to the predicted tables. Loads outside their
   // table are dropped; a feature beyond the buffer is dropped as well, but
   // its last flag still runs the network.
   task automatic absorb_beat(input req_type b, output bit produced, output rsp_type verdict);
      produced = 1'b0;
      verdict  = '0;
      case (b.operation)
         OP_HIDDEN_WEIGHT: begin
            if (b.row_index < N_HID && b.column_index < N_IN)
               hid_w[b.row_index][b.column_index] = b.value;
         end
         OP_HIDDEN_BIAS: begin
            if (b.row_index < N_HID) hid_b[b.row_index] = b.value;
         end
         OP_OUTPUT_WEIGHT: begin
            if (b.row_index < N_CLS && b.column_index < N_HID)
               out_w[b.row_index][b.column_index] = b.value;
         end
         OP_OUTPUT_BIAS: begin
            if (b.row_index < N_CLS) out_b[b.row_index] = b.value;
         end
         OP_FEATURE: begin
            if (b.column_index < N_IN) feat[b.column_index] = b.value;
            if (b.last_feature) begin
               verdict  = classify_sample();
               produced = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // True for beats that change nothing and produce nothing.
   function automatic bit is_ignored(input req_type b);
      case (b.operation)
         OP_HIDDEN_WEIGHT: return !(b.row_index < N_HID && b.column_index < N_IN);
         OP_HIDDEN_BIAS:   return !(b.row_index < N_HID);
         OP_OUTPUT_WEIGHT: return !(b.row_index < N_CLS && b.column_index < N_HID);
         OP_OUTPUT_BIAS:   return !(b.row_index < N_CLS);
         OP_FEATURE:       return !(b.column_index < N_IN) && !b.last_feature;
         default:          return 1'b1;
      endcase
   endfunction

   function automatic req_type make_beat(input int op, input int row, input int col,
                                         input logic [31:0] val, input int last);
      req_type b;
      b.operation    = 3'(op);
      b.row_index    = 6'(row);
      b.column_index = 6'(col);
      b.value        = val;
      b.last_feature = 1'(last);
      return b;
   endfunction

   // Operand values: mostly small numbers so that logits stay meaningful,
   // with full-width words and the corner values mixed in.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 32) - 16;
         4, 5, 6:    return $urandom;
         7: begin
            case ($urandom_range(0, 4))
               0:       return 32'h0000_0000;
               1:       return 32'h0000_0001;
               2:       return 32'hFFFF_FFFF;
               3:       return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         default:    return $urandom_range(0, 8192) - 4096;
      endcase
   endfunction

   // Presents one beat and holds it until the block takes it. Idle cycles
   // in front of the beat carry junk on req_data with start low. Inputs
   // only ever change on the falling edge, so every signal receives at most
   // one assignment per time step.
   task automatic send_beat(input req_type b, input int typed, input rsp_type want);
      bit         produced;
      rsp_type    predicted;
      logic [63:0] junk;
      if (!steady) begin
         while ($urandom_range(0, 99) < 34) begin
            junk = {$urandom, $urandom};
            @(negedge clock);
            start    <= 1'b0;
            req_data <= junk[$bits(req_type)-1:0];
            @(posedge clock);
         end
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      absorb_beat(b, produced, predicted);
      if (is_ignored(b)) ignored_beats++;
      if (produced) expected_verdicts.push_back((typed != 0) ? want : predicted);
   endtask

   // Holds the sender back until every classification owed has arrived.
   task automatic drain_verdicts();
      @(negedge clock);
      start <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result checker and stall counter. Results cannot be held off, so
   // each one is compared on the very edge that ends its strobe.
   // ------------------------------------------------------------------
   rsp_type oldest;

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (start && !busy) beats_taken++;
         if (rsp_valid) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result, expected nothing, actual class %0d logit %0d",
                        $time, rsp_data.predicted_class, rsp_data.top_logit);
               mismatches++;
            end else begin
               oldest = expected_verdicts.pop_front();
               verdicts_checked++;
               if (rsp_data.predicted_class !== oldest.predicted_class) begin
                  $display("%0t: predicted_class mismatch, expected %0d, actual %0d",
                           $time, oldest.predicted_class, rsp_data.predicted_class);
                  mismatches++;
               end
               if (rsp_data.top_logit !== oldest.top_logit) begin
                  $display("%0t: top_logit mismatch, expected %0d, actual %0d",
                           $time, oldest.top_logit, rsp_data.top_logit);
                  mismatches++;
               end
            end
         end
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
      end
   end

   // Watchdog: the block has stopped taking beats or giving results.
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("mlp_two_layer_classifier test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Directed stimulus table. Rows with a typed verdict are ones whose
   // answer is plain from the tables at that point; all others are left to
   // the predictor.
   // ------------------------------------------------------------------
   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows [$];

   task automatic add_row(input int op, input int row, input int col,
                          input logic [31:0] val, input int last,
                          input int typed = 0, input int cls = 0,
                          input logic [31:0] logit = '0);
      stim_row_type r;
      r.beat                 = make_beat(op, row, col, val, last);
      r.typed                = 1'(typed);
      r.want.predicted_class = 7'(cls);
      r.want.top_logit       = logit;
      directed_rows.push_back(r);
   endtask

   initial begin
      req_type b;
      int      useful;
      int      n;
      int      kind;
      int      target;
      bit      drained_midway;

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block does not clear its tables, so every entry is written with
      // zero before any inference can read it. From then on every entry
      // holds a defined value and any sequence of beats is legal.
      for (int h = 0; h < N_HID; h++) begin
         for (int i = 0; i < N_IN; i++) send_beat(make_beat(OP_HIDDEN_WEIGHT, h, i, 0, 0), 0, '0);
         send_beat(make_beat(OP_HIDDEN_BIAS, h, 0, 0, 0), 0, '0);
      end
      for (int c = 0; c < N_CLS; c++) begin
         for (int h = 0; h < N_HID; h++) send_beat(make_beat(OP_OUTPUT_WEIGHT, c, h, 0, 0), 0, '0);
         send_beat(make_beat(OP_OUTPUT_BIAS, c, 0, 0, 0), 0, '0);
      end
      for (int i = 0; i < N_IN; i++) send_beat(make_beat(OP_FEATURE, 0, i, 0, 0), 0, '0);

      // With everything zero all logits tie at zero and class one wins.
      add_row(OP_FEATURE, 0, 0, 32'h0, 1, 1, 1, 32'h0);
      // A largest positive bias on the last class makes it win outright.
      add_row(OP_OUTPUT_BIAS, 3, 0, 32'h7FFF_FFFF, 0);
      add_row(OP_FEATURE, 0, 15, 32'h0, 1, 1, 4, 32'h7FFF_FFFF);
      // Same bias on class one: a tie between first and last goes to the first.
      add_row(OP_OUTPUT_BIAS, 0, 0, 32'h7FFF_FFFF, 0);
      add_row(OP_FEATURE, 0, 7, 32'h0, 1, 1, 1, 32'h7FFF_FFFF);
      // Loads beyond their tables are dropped, and the last flag on a load
      // starts nothing.
      add_row(OP_OUTPUT_BIAS, 4, 0, 32'h8000_0000, 1);
      add_row(OP_HIDDEN_WEIGHT, 63, 63, 32'hFFFF_FFFF, 0);
      add_row(OP_HIDDEN_BIAS, 16, 0, 32'hFFFF_FFFF, 0);
      add_row(OP_OUTPUT_WEIGHT, 4, 15, 32'hFFFF_FFFF, 0);
      add_row(OP_OUTPUT_WEIGHT, 0, 16, 32'hFFFF_FFFF, 0);
      add_row(OP_HIDDEN_WEIGHT, 0, 16, 32'hFFFF_FFFF, 0);
      // Undefined operation codes are ignored even with the last flag set.
      add_row(OP_SPARE_5, 0, 0, 32'h0, 1);
      add_row(OP_SPARE_6, 21, 42, 32'h5555_5555, 1);
      add_row(OP_SPARE_7, 63, 63, 32'hFFFF_FFFF, 1);
      // A feature past the end of the buffer is not stored but still runs
      // the network, which is unchanged by all of the above.
      add_row(OP_FEATURE, 63, 63, 32'h7FFF_FFFF, 1, 1, 1, 32'h7FFF_FFFF);
      // From here on the predictor decides: wrapping products, ReLU of a
      // negative sum, and a doubled largest bias that wraps negative.
      add_row(OP_OUTPUT_BIAS, 0, 0, 32'h8000_0000, 0);
      add_row(OP_OUTPUT_BIAS, 3, 0, 32'h8000_0000, 0);
      add_row(OP_FEATURE, 0, 0, 32'h8000_0000, 0);
      add_row(OP_HIDDEN_WEIGHT, 0, 0, 32'hFFFF_FFFF, 0);
      add_row(OP_HIDDEN_BIAS, 15, 0, 32'h7FFF_FFFF, 0);
      add_row(OP_OUTPUT_WEIGHT, 2, 15, 32'h0000_0002, 0);
      add_row(OP_FEATURE, 0, 15, 32'h7FFF_FFFF, 1);
      add_row(OP_OUTPUT_WEIGHT, 1, 15, 32'hFFFF_FFFF, 0);
      add_row(OP_HIDDEN_WEIGHT, 15, 1, 32'h0000_0003, 0);
      add_row(OP_FEATURE, 0, 1, 32'hFFFF_FFFF, 1);

      foreach (directed_rows[k])
         send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);

      // Let the directed results all arrive before the random part begins.
      drain_verdicts();

      // Random part. Most of it is well-formed: whole samples of features
      // ending in a last beat, and table reloads. A smaller share is noise:
      // spare codes, loads with the last flag, and features beyond the
      // buffer. Only beats that do something count towards the total.
      useful         = 0;
      drained_midway = 1'b0;
      while (useful < RANDOM_BEATS) begin
         // A long stretch in the middle runs with no sender gaps at all.
         steady = (useful >= 700 && useful < 1000);
         if (!drained_midway && useful >= 1200) begin
            drain_verdicts();
            drained_midway = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // A sample: usually the full buffer in order, sometimes a partial
            // update in scattered positions.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, N_IN - 1) : N_IN;
            for (int i = 0; i < n; i++) begin
               b = make_beat(OP_FEATURE, $urandom_range(0, 63),
                             (n == N_IN) ? i : $urandom_range(0, N_IN - 1),
                             pick_value(), i == n - 1);
               send_beat(b, 0, '0);
               useful++;
            end
         end else if (kind < 80) begin
            // A burst of scattered loads, now and then beyond their tables.
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) begin
               b = make_beat($urandom_range(OP_HIDDEN_WEIGHT, OP_OUTPUT_BIAS),
                             $urandom_range(0, 15), $urandom_range(0, 15),
                             pick_value(), $urandom_range(0, 1));
               if (b.operation == OP_OUTPUT_WEIGHT || b.operation == OP_OUTPUT_BIAS)
                  b.row_index = 6'($urandom_range(0, N_CLS - 1));
               if ($urandom_range(0, 9) == 0) begin
                  b.row_index    = 6'($urandom_range(0, 63));
                  b.column_index = 6'($urandom_range(0, 63));
               end
               send_beat(b, 0, '0);
               if (!is_ignored(b)) useful++;
            end
         end else if (kind < 92) begin
            // Reload one whole neuron: its weights followed by its bias.
            if ($urandom_range(0, 1)) begin
               target = $urandom_range(0, N_HID - 1);
               for (int i = 0; i < N_IN; i++)
                  send_beat(make_beat(OP_HIDDEN_WEIGHT, target, i, pick_value(), 0), 0, '0);
               send_beat(make_beat(OP_HIDDEN_BIAS, target, 0, pick_value(), 0), 0, '0);
            end else begin
               target = $urandom_range(0, N_CLS - 1);
               for (int h = 0; h < N_HID; h++)
                  send_beat(make_beat(OP_OUTPUT_WEIGHT, target, h, pick_value(), 0), 0, '0);
               send_beat(make_beat(OP_OUTPUT_BIAS, target, 0, pick_value(), 0), 0, '0);
            end
            useful += N_IN + 1;
         end else begin
            case ($urandom_range(0, 2))
               0: b = make_beat($urandom_range(OP_SPARE_5, OP_SPARE_7), $urandom_range(0, 63),
                                $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
               1: b = make_beat($urandom_range(OP_HIDDEN_WEIGHT, OP_OUTPUT_BIAS),
                                $urandom_range(0, 63), $urandom_range(0, 63), $urandom, 1);
               default: b = make_beat(OP_FEATURE, $urandom_range(0, 63),
                                      $urandom_range(N_IN, 63), $urandom,
                                      $urandom_range(0, 1));
            endcase
            send_beat(b, 0, '0);
            if (!is_ignored(b)) useful++;
         end
      end

      @(negedge clock);
      start <= 1'b0;
      steady = 1'b0;

      // Wait for the last classification, then long enough for the block to
      // show any result it should not have produced.
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d beats, %0d of them ignored codes or out-of-range loads,",
               beats_taken, ignored_beats);
      $display("and %0d classifications checked field by field.", verdicts_checked);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("mlp_two_layer_classifier test passed");
      end else begin
         $display("mlp_two_layer_classifier test failed");
      end
      $finish;
   end

endmodule
